/* rtl/core/crce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_pkg
// Shared types, register codes and bit-level helpers for the checksum engine.
// ----------------------------------------------------------------------------
package crce_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned CrcW   = 32;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned CfgIdxW = 3;

    // Mode codes.
    localparam logic [ModeW-1:0] MODE_XOR   = 2'd0;
    localparam logic [ModeW-1:0] MODE_CRC8  = 2'd1;
    localparam logic [ModeW-1:0] MODE_CRC16 = 2'd2;
    localparam logic [ModeW-1:0] MODE_CRC32 = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MODE        = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_POLYNOMIAL  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INIT_VALUE  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_FINAL_XOR   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_REFLECT_IN  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_REFLECT_OUT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [ModeW-1:0] RST_MODE       = MODE_CRC32;
    localparam logic [CrcW-1:0]  RST_POLYNOMIAL = 32'h04C1_1DB7;
    localparam logic [CrcW-1:0]  RST_INIT_VALUE = 32'hFFFF_FFFF;
    localparam logic [CrcW-1:0]  RST_FINAL_XOR  = 32'hFFFF_FFFF;
    localparam logic             RST_REFLECT_IN  = 1'b1;
    localparam logic             RST_REFLECT_OUT = 1'b1;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [CrcW-1:0]  polynomial;
        logic [CrcW-1:0]  init_value;
        logic [CrcW-1:0]  final_xor;
        logic             reflect_input;
        logic             reflect_output;
    } cfg_t;

    // CRC registers are handled aligned to the top of a 32-bit word, so the
    // same shift network serves every width and bits above the width fall off.
    function automatic logic [CrcW-1:0] align_top(
        input logic [CrcW-1:0]  value,
        input logic [ModeW-1:0] mode
    );
        logic [CrcW-1:0] r;
        case (mode)
            MODE_CRC8:  r = {value[7:0], 24'd0};
            MODE_CRC16: r = {value[15:0], 16'd0};
            default:    r = value;
        endcase
        return r;
    endfunction

    function automatic logic [CrcW-1:0] align_bottom(
        input logic [CrcW-1:0]  value,
        input logic [ModeW-1:0] mode
    );
        logic [CrcW-1:0] r;
        case (mode)
            MODE_CRC8:  r = {24'd0, value[31:24]};
            MODE_CRC16: r = {16'd0, value[31:16]};
            default:    r = value;
        endcase
        return r;
    endfunction

    function automatic logic [DataW-1:0] reverse8(input logic [DataW-1:0] v);
        logic [DataW-1:0] r;
        for (int i = 0; i < DataW; i++) begin
            r[i] = v[DataW-1-i];
        end
        return r;
    endfunction

    function automatic logic [CrcW-1:0] reverse32(input logic [CrcW-1:0] v);
        logic [CrcW-1:0] r;
        for (int i = 0; i < CrcW; i++) begin
            r[i] = v[CrcW-1-i];
        end
        return r;
    endfunction

endpackage

/* rtl/core/crce_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_cfg_regs
// Configuration register file, written through an index/data request port.
// ----------------------------------------------------------------------------
module crce_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crce_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [crce_pkg::CrcW-1:0]    cfg_data,
    output crce_pkg::cfg_t               cfg
);
    import crce_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= RST_MODE;
            cfg_reg.polynomial     <= RST_POLYNOMIAL;
            cfg_reg.init_value     <= RST_INIT_VALUE;
            cfg_reg.final_xor      <= RST_FINAL_XOR;
            cfg_reg.reflect_input  <= RST_REFLECT_IN;
            cfg_reg.reflect_output <= RST_REFLECT_OUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:        cfg_reg.mode           <= cfg_data[ModeW-1:0];
                REG_POLYNOMIAL:  cfg_reg.polynomial     <= cfg_data;
                REG_INIT_VALUE:  cfg_reg.init_value     <= cfg_data;
                REG_FINAL_XOR:   cfg_reg.final_xor      <= cfg_data;
                REG_REFLECT_IN:  cfg_reg.reflect_input  <= cfg_data[0];
                REG_REFLECT_OUT: cfg_reg.reflect_output <= cfg_data[0];
                default:         ;
            endcase
        end
    end

endmodule

/* rtl/core/crce_byte_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_byte_update
// Folds one message byte into the running accumulator, combinationally.
// ----------------------------------------------------------------------------
module crce_byte_update (
    input  crce_pkg::cfg_t                acc_cfg,
    input  logic [crce_pkg::CrcW-1:0]     acc,
    input  logic [crce_pkg::DataW-1:0]    data_byte,
    input  logic                          carries_byte,
    input  logic                          is_first,
    output logic [crce_pkg::CrcW-1:0]     acc_new
);
    import crce_pkg::*;

    logic [DataW-1:0] xor_acc;
    logic [DataW-1:0] byte_in;
    logic [CrcW-1:0]  top_reg;
    logic [CrcW-1:0]  top_poly;

    always_comb
    begin
        // Byte-XOR mode.
        xor_acc = is_first ? '0 : acc[DataW-1:0];
        if (carries_byte)
        begin
            xor_acc = xor_acc ^ data_byte;
        end

        // CRC modes, eight MSB-first steps on the top-aligned register.
        byte_in  = acc_cfg.reflect_input ? reverse8(data_byte) : data_byte;
        top_poly = align_top(acc_cfg.polynomial, acc_cfg.mode);
        top_reg  = align_top(is_first ? acc_cfg.init_value : acc, acc_cfg.mode);
        if (carries_byte)
        begin
            top_reg[CrcW-1 -: DataW] = top_reg[CrcW-1 -: DataW] ^ byte_in;
            for (int i = 0; i < DataW; i++) begin
                if (top_reg[CrcW-1])
                begin
                    top_reg = {top_reg[CrcW-2:0], 1'b0} ^ top_poly;
                end
                else
                begin
                    top_reg = {top_reg[CrcW-2:0], 1'b0};
                end
            end
        end

        if (acc_cfg.mode == MODE_XOR)
        begin
            acc_new = {{(CrcW-DataW){1'b0}}, xor_acc};
        end
        else
        begin
            acc_new = align_bottom(top_reg, acc_cfg.mode);
        end
    end

endmodule

/* rtl/core/crce_finalize.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_finalize
// Turns the accumulator into the checksum: output reflection and final XOR.
// ----------------------------------------------------------------------------
module crce_finalize (
    input  crce_pkg::cfg_t             fin_cfg,
    input  logic [crce_pkg::CrcW-1:0]  acc,
    output logic [crce_pkg::CrcW-1:0]  checksum
);
    import crce_pkg::*;

    logic [CrcW-1:0] top_val;
    logic [CrcW-1:0] refl_val;

    always_comb
    begin
        top_val = align_top(acc, fin_cfg.mode);
        // Reversing the top-aligned word reverses the value over its own width.
        refl_val = fin_cfg.reflect_output ? reverse32(top_val)
                                          : align_bottom(top_val, fin_cfg.mode);
        if (fin_cfg.mode == MODE_XOR)
        begin
            checksum = {{(CrcW-DataW){1'b0}}, acc[DataW-1:0]};
        end
        else
        begin
            checksum = align_bottom(align_top(refl_val ^ fin_cfg.final_xor,
                                              fin_cfg.mode), fin_cfg.mode);
        end
    end

endmodule

/* rtl/core/configurable_crc_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_crc_engine_core
// Byte-serial checksum engine: XOR of bytes, CRC-8, CRC-16 or CRC-32.
// ----------------------------------------------------------------------------
// One message byte is taken per request and the engine sustains one request
// per clock. Each accepted request sits in an input register, where the
// full eight-bit CRC step, and on the last request the output reflection
// and final XOR, are done by one combinational network; the checksum then
// lands in an output register, so a request marked last shows its checksum
// once it has passed both registers. The input only stalls when a last
// request finds a checksum still held by a stalled output. The CRC register
// is kept aligned to the top of a 32-bit word so that all widths share the
// same shift network. Configuration may be written only while no message
// request is in flight; the configuration port is always ready.
// ----------------------------------------------------------------------------
module configurable_crc_engine_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [crce_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [crce_pkg::CrcW-1:0]    cfg_data,
    // message input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [crce_pkg::DataW-1:0]   data_byte,
    input  logic                         carries_byte,
    input  logic                         is_first,
    input  logic                         is_last,
    // checksum output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [crce_pkg::CrcW-1:0]    checksum
);
    import crce_pkg::*;

    cfg_t             cfg;

    logic             in_valid_reg;
    logic [DataW-1:0] data_byte_reg;
    logic             carries_byte_reg;
    logic             is_first_reg;
    logic             is_last_reg;

    logic [CrcW-1:0]  acc_reg;
    logic [CrcW-1:0]  acc_next;
    logic [CrcW-1:0]  checksum_next;

    logic             out_valid_reg;
    logic [CrcW-1:0]  checksum_reg;

    logic             advance;
    logic             in_accept;

    crce_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crce_byte_update u_update (
        .acc_cfg      (cfg),
        .acc          (acc_reg),
        .data_byte    (data_byte_reg),
        .carries_byte (carries_byte_reg),
        .is_first     (is_first_reg),
        .acc_new      (acc_next)
    );

    crce_finalize u_final (
        .fin_cfg  (cfg),
        .acc      (acc_next),
        .checksum (checksum_next)
    );

    // A held request moves on unless it needs the output slot and that slot
    // is occupied by a checksum the consumer has not taken yet.
    assign advance   = in_valid_reg && (!is_last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                acc_reg <= acc_next;
            end
            if (advance && is_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_byte_reg    <= data_byte;
            carries_byte_reg <= carries_byte;
            is_first_reg     <= is_first;
            is_last_reg      <= is_last;
        end
        if (advance && is_last_reg)
        begin
            checksum_reg <= checksum_next;
        end
    end

endmodule
